// ===== design/lzwd_pkg.sv =====
// lzwd_pkg: shared types and constants for the lzw code decoder
// used by every module of the block except lzwd_ram; no dependencies
package lzwd_pkg;

    localparam int CODE_W        = 9;
    localparam int BYTE_W        = 8;
    localparam int NFC_W         = 10;
    localparam int LIT_LIMIT     = 256;
    localparam int DICT_SIZE_DEF = 512;
    localparam int STACK_DEPTH   = 257;
    localparam int STACK_AW      = 9;
    localparam int CHUNK_BYTES   = 8;
    localparam int CHUNK_W       = CHUNK_BYTES * BYTE_W;
    localparam int CNT_W         = 4;
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = 1;

    // item classes decided by the front end
    typedef enum logic [1:0] {
        K_ERR  = 2'd0,
        K_LIT  = 2'd1,
        K_CODE = 2'd2,
        K_KWK  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] ecode;
        logic              evalid;
    } t_item;

endpackage

// ===== design/lzw_code_decoder_top.sv =====
// lzw_code_decoder_top: a code of L bytes walks W dictionary steps (W = L-1, or L-2 on the
// kwkwk path); the back end reads one entry per cycle on the walk, then writes the tail byte
// and reads the stack one byte per cycle within a chunk while the output takes chunks; an
// error item gives a single result with o_error set; a two-item queue keeps accepting codes
// meanwhile; reset (i_rst_n, synchronous, active low) clears control state and restarts at
// code 256; dictionary and stack contents are kept
module lzw_code_decoder_top #(
    parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lzwd_pkg::CODE_W-1:0]  i_code,
    input  logic                         i_first_of_message,
    // result item channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lzwd_pkg::CHUNK_W-1:0] o_chunk,
    output logic [lzwd_pkg::CNT_W-1:0]   o_byte_count,
    output logic                         o_last,
    output logic [lzwd_pkg::CODE_W-1:0]  o_new_entry_code,
    output logic                         o_new_entry_valid,
    output logic                         o_error
);

    // front end to queue
    logic            push_valid;
    logic            push_ready;
    lzwd_pkg::t_item push_item;

    // queue to back end
    logic            pop_valid;
    logic            pop_ready;
    lzwd_pkg::t_item pop_item;

    // front end: keeps the next free code so each item arrives already classified
    // as error, first literal, plain code or kwkwk, with its new entry number
    lzwd_front #(
        .DICT_SIZE (DICT_SIZE)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_code             (i_code),
        .i_first_of_message (i_first_of_message),
        .o_push_valid       (push_valid),
        .i_push_ready       (push_ready),
        .o_item             (push_item)
    );

    // decouples acceptance from the multi-cycle decode
    lzwd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_item       (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_item       (pop_item)
    );

    // back end: owns the dictionary, previous code, first byte and reversal stack;
    // results leave through an output register so decoding continues while one waits
    lzwd_back #(
        .DICT_SIZE (DICT_SIZE)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (pop_valid),
        .o_q_ready         (pop_ready),
        .i_q_item          (pop_item),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_chunk           (o_chunk),
        .o_byte_count      (o_byte_count),
        .o_last            (o_last),
        .o_new_entry_code  (o_new_entry_code),
        .o_new_entry_valid (o_new_entry_valid),
        .o_error           (o_error)
    );

endmodule

// ===== design/lzwd_ram.sv =====
// lzwd_ram: generic single write port ram with registered read
// no dependencies
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lzwd_front.sv =====
// lzwd_front: accepts codes, tracks the next free code and classifies each item
// depends on lzwd_pkg
module lzwd_front #(
    parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lzwd_pkg::CODE_W-1:0] i_code,
    input  logic                        i_first_of_message,
    output logic                        o_push_valid,
    input  logic                        i_push_ready,
    output lzwd_pkg::t_item             o_item
);

    logic [lzwd_pkg::NFC_W-1:0] r_nfc;
    logic [lzwd_pkg::NFC_W-1:0] n_nfc;
    logic                       accept;
    logic                       room;

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign accept       = i_valid & i_push_ready;
    assign room         = r_nfc < lzwd_pkg::NFC_W'(DICT_SIZE);

    always_comb begin
        o_item.code   = i_code;
        o_item.ecode  = '0;
        o_item.evalid = 1'b0;
        if (i_first_of_message) begin
            o_item.kind = (i_code >= lzwd_pkg::CODE_W'(lzwd_pkg::LIT_LIMIT)) ?
                          lzwd_pkg::K_ERR : lzwd_pkg::K_LIT;
        end else begin
            o_item.kind = ({1'b0, i_code} >= r_nfc) ? lzwd_pkg::K_KWK : lzwd_pkg::K_CODE;
            if (room) begin
                o_item.ecode  = r_nfc[lzwd_pkg::CODE_W-1:0];
                o_item.evalid = 1'b1;
            end
        end
    end

    always_comb begin
        n_nfc = r_nfc;
        if (accept) begin
            if (i_first_of_message) begin
                n_nfc = lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);
            end else if (room) begin
                n_nfc = r_nfc + lzwd_pkg::NFC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfc <= lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);
        end else begin
            r_nfc <= n_nfc;
        end
    end

endmodule

// ===== design/lzwd_queue.sv =====
// lzwd_queue: short item queue between front end and back end
// depends on lzwd_pkg
module lzwd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  lzwd_pkg::t_item i_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output lzwd_pkg::t_item o_item
);

    lzwd_pkg::t_item               r_mem [lzwd_pkg::Q_DEPTH];
    logic [lzwd_pkg::Q_AW-1:0]     r_wp;
    logic [lzwd_pkg::Q_AW-1:0]     r_rp;
    logic [lzwd_pkg::Q_AW:0]       r_cnt;
    logic                          push;
    logic                          pop;

    assign o_push_ready = r_cnt != (lzwd_pkg::Q_AW + 1)'(lzwd_pkg::Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + lzwd_pkg::Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + lzwd_pkg::Q_AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (lzwd_pkg::Q_AW + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (lzwd_pkg::Q_AW + 1)'(1);
            end
        end
    end

endmodule

// ===== design/lzwd_back.sv =====
// lzwd_back: walks prefix chains into the reversal stack and emits chunks
// depends on lzwd_pkg and lzwd_ram
module lzwd_back #(
    parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  lzwd_pkg::t_item              i_q_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lzwd_pkg::CHUNK_W-1:0] o_chunk,
    output logic [lzwd_pkg::CNT_W-1:0]   o_byte_count,
    output logic                         o_last,
    output logic [lzwd_pkg::CODE_W-1:0]  o_new_entry_code,
    output logic                         o_new_entry_valid,
    output logic                         o_error
);

    localparam int ENTRY_DEPTH = DICT_SIZE - lzwd_pkg::LIT_LIMIT;
    localparam int ENTRY_AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int ENTRY_W     = lzwd_pkg::CODE_W + lzwd_pkg::BYTE_W;
    localparam int CW          = lzwd_pkg::CODE_W;
    localparam int BW          = lzwd_pkg::BYTE_W;
    localparam int SAW         = lzwd_pkg::STACK_AW;
    localparam int NW          = lzwd_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_TAIL = 5'b00100,
        S_EMIT = 5'b01000,
        S_ERR  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    lzwd_pkg::t_item r_item, n_item;
    logic [CW-1:0]  r_c, n_c;
    logic [SAW-1:0] r_d, n_d;
    logic [CW-1:0]  r_prev, n_prev;
    logic [BW-1:0]  r_cfb, n_cfb;
    logic [SAW-1:0] r_left, n_left;
    logic [NW-1:0]  r_iss, n_iss;
    logic           r_pend, n_pend;
    logic [lzwd_pkg::CHUNK_W-1:0] r_acc, n_acc;

    logic                         r_o_valid, n_o_valid;
    logic [lzwd_pkg::CHUNK_W-1:0] r_o_chunk, n_o_chunk;
    logic [NW-1:0]                r_o_count, n_o_count;
    logic                         r_o_last, n_o_last;
    logic [CW-1:0]                r_o_ecode, n_o_ecode;
    logic                         r_o_evalid, n_o_evalid;
    logic                         r_o_error, n_o_error;

    logic                dict_we;
    logic [ENTRY_AW-1:0] dict_waddr;
    logic [ENTRY_W-1:0]  dict_wdata;
    logic [ENTRY_AW-1:0] dict_raddr;
    logic [ENTRY_W-1:0]  dict_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr;
    logic [BW-1:0]       stk_wdata;
    logic [SAW-1:0]      stk_raddr;
    logic [BW-1:0]       stk_rdata;

    logic           out_free;
    logic [CW-1:0]  start_c;
    logic [SAW-1:0] start_d;
    logic [CW-1:0]  walk_c;
    logic [SAW-1:0] walk_d;
    logic [2:0]     arr_idx;
    logic           issue;
    logic           flush;

    lzwd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_DEPTH),
        .AW    (ENTRY_AW)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (dict_we),
        .i_waddr (dict_waddr),
        .i_wdata (dict_wdata),
        .i_raddr (dict_raddr),
        .o_rdata (dict_rdata)
    );

    lzwd_ram #(
        .WIDTH (BW),
        .DEPTH (lzwd_pkg::STACK_DEPTH),
        .AW    (SAW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign out_free  = ~r_o_valid | i_ready;
    assign o_q_ready = r_state == S_IDLE;
    assign start_c   = (i_q_item.kind == lzwd_pkg::K_KWK) ? r_prev : i_q_item.code;
    assign start_d   = (i_q_item.kind == lzwd_pkg::K_KWK) ? SAW'(1) : '0;
    assign walk_c    = dict_rdata[ENTRY_W-1:BW];
    assign walk_d    = r_d + SAW'(1);
    assign arr_idx   = 3'(r_iss - NW'(1));
    assign issue     = (r_left != '0) && (r_iss != NW'(lzwd_pkg::CHUNK_BYTES));
    assign flush     = !r_pend && (r_iss != '0) &&
                       ((r_iss == NW'(lzwd_pkg::CHUNK_BYTES)) || (r_left == '0));

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_c        = r_c;
        n_d        = r_d;
        n_prev     = r_prev;
        n_cfb      = r_cfb;
        n_left     = r_left;
        n_iss      = r_iss;
        n_pend     = 1'b0;
        n_acc      = r_acc;
        n_o_valid  = r_o_valid & ~i_ready;
        n_o_chunk  = r_o_chunk;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        n_o_ecode  = r_o_ecode;
        n_o_evalid = r_o_evalid;
        n_o_error  = r_o_error;
        dict_we    = 1'b0;
        dict_waddr = r_item.ecode[ENTRY_AW-1:0];
        dict_wdata = {r_prev, r_c[BW-1:0]};
        dict_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = r_d;
        stk_wdata  = r_c[BW-1:0];
        stk_raddr  = r_left - SAW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_item = i_q_item;
                    if (i_q_item.kind == lzwd_pkg::K_ERR) begin
                        n_state = S_ERR;
                    end else begin
                        // kwkwk: the current first byte sits at the bottom of the stack
                        if (i_q_item.kind == lzwd_pkg::K_KWK) begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = r_cfb;
                        end
                        n_c = start_c;
                        n_d = start_d;
                        if (start_c >= CW'(lzwd_pkg::LIT_LIMIT)) begin
                            dict_raddr = start_c[ENTRY_AW-1:0];
                            n_state    = S_WALK;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end
                end
            end
            S_WALK: begin
                stk_we    = 1'b1;
                stk_wdata = dict_rdata[BW-1:0];
                n_c       = walk_c;
                n_d       = walk_d;
                // follow the chain while it names an entry and the stack has room
                if (walk_c >= CW'(lzwd_pkg::LIT_LIMIT) &&
                    walk_d < SAW'(lzwd_pkg::LIT_LIMIT)) begin
                    dict_raddr = walk_c[ENTRY_AW-1:0];
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                stk_we  = 1'b1;
                dict_we = r_item.evalid;
                n_left  = walk_d;
                n_prev  = r_item.code;
                n_cfb   = r_c[BW-1:0];
                n_iss   = '0;
                n_acc   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_pend) begin
                    n_acc[{arr_idx, 3'b000} +: BW] = stk_rdata;
                end
                if (issue) begin
                    n_left = r_left - SAW'(1);
                    n_iss  = r_iss + NW'(1);
                    n_pend = 1'b1;
                end
                if (flush && out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_chunk  = r_acc;
                    n_o_count  = r_iss;
                    n_o_last   = r_left == '0;
                    n_o_ecode  = r_item.ecode;
                    n_o_evalid = r_item.evalid;
                    n_o_error  = 1'b0;
                    n_acc      = '0;
                    n_iss      = '0;
                    if (r_left == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_chunk  = '0;
                    n_o_count  = '0;
                    n_o_last   = 1'b1;
                    n_o_ecode  = '0;
                    n_o_evalid = 1'b0;
                    n_o_error  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '0;
            r_cfb     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_cfb     <= n_cfb;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_c        <= n_c;
        r_d        <= n_d;
        r_left     <= n_left;
        r_iss      <= n_iss;
        r_acc      <= n_acc;
        r_o_chunk  <= n_o_chunk;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
        r_o_ecode  <= n_o_ecode;
        r_o_evalid <= n_o_evalid;
        r_o_error  <= n_o_error;
    end

    assign o_valid           = r_o_valid;
    assign o_chunk           = r_o_chunk;
    assign o_byte_count      = r_o_count;
    assign o_last            = r_o_last;
    assign o_new_entry_code  = r_o_ecode;
    assign o_new_entry_valid = r_o_evalid;
    assign o_error           = r_o_error;

endmodule

// ===== tb/lzw_code_decoder_checker.sv =====
`timescale 1ns / 1ps
// lzw_code_decoder_checker: watches both item channels of the lzw code decoder,
// predicts the decoded chunks of every accepted code and compares them in order
// depends on lzwd_pkg for widths and constants
module lzw_code_decoder_checker #(
    parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [lzwd_pkg::CODE_W-1:0]  i_code,
    input  logic                         i_first_of_message,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [lzwd_pkg::CHUNK_W-1:0] i_chunk,
    input  logic [lzwd_pkg::CNT_W-1:0]   i_byte_count,
    input  logic                         i_last,
    input  logic [lzwd_pkg::CODE_W-1:0]  i_new_entry_code,
    input  logic                         i_new_entry_valid,
    input  logic                         i_error,
    output int                           o_mismatch_count,
    output int                           o_outstanding
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [lzwd_pkg::CHUNK_W-1:0] chunk;
        logic [lzwd_pkg::CNT_W-1:0]   byte_count;
        logic                         last;
        logic [lzwd_pkg::CODE_W-1:0]  entry_code;
        logic                         entry_valid;
        logic                         error;
    } t_chunk;

    // decoder state as the block should hold it
    logic [lzwd_pkg::CODE_W-1:0] dict_prefix [lzwd_pkg::LIT_LIMIT];
    logic [lzwd_pkg::BYTE_W-1:0] dict_tail [lzwd_pkg::LIT_LIMIT];
    logic [lzwd_pkg::BYTE_W-1:0] byte_stack [lzwd_pkg::STACK_DEPTH];
    logic [lzwd_pkg::CODE_W-1:0] last_code;
    logic [lzwd_pkg::BYTE_W-1:0] string_head;
    logic [lzwd_pkg::NFC_W-1:0]  free_code;

    t_chunk pending_chunks [$];
    int     mismatch_count = 0;

    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // add one predicted chunk at the tail of the queue
    task automatic queue_chunk(input t_chunk item);
        pending_chunks.insert(pending_chunks.size(), item);
    endtask

    // push the string of a code tail first; returns the new stack depth
    function automatic int unsigned push_string(input logic [lzwd_pkg::CODE_W-1:0] start,
                                                input int unsigned steps,
                                                input int unsigned depth);
        logic [lzwd_pkg::CODE_W-1:0] c;
        c = start;
        while (c >= lzwd_pkg::LIT_LIMIT && steps > 0 && depth < lzwd_pkg::LIT_LIMIT) begin
            byte_stack[depth] = dict_tail[c[lzwd_pkg::BYTE_W-1:0]];
            depth++;
            c = dict_prefix[c[lzwd_pkg::BYTE_W-1:0]];
            steps--;
        end
        byte_stack[depth] = c[lzwd_pkg::BYTE_W-1:0];
        return depth + 1;
    endfunction

    task automatic decode_code(input logic [lzwd_pkg::CODE_W-1:0] code, input logic first);
        int unsigned                 depth;
        int unsigned                 left;
        int unsigned                 cnt;
        logic [lzwd_pkg::BYTE_W-1:0] head;
        logic [lzwd_pkg::CODE_W-1:0] ecode;
        logic                        evalid;
        t_chunk                      r;
        ecode  = '0;
        evalid = 1'b0;
        if (first) begin
            free_code = lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);
            if (code >= lzwd_pkg::LIT_LIMIT) begin
                r       = '0;
                r.last  = 1'b1;
                r.error = 1'b1;
                queue_chunk(r);
                return;
            end
            byte_stack[0] = code[lzwd_pkg::BYTE_W-1:0];
            depth         = 1;
            last_code     = code;
            string_head   = code[lzwd_pkg::BYTE_W-1:0];
        end else begin
            if (code >= free_code) begin
                // code not in the table yet: previous string plus its own head
                byte_stack[0] = string_head;
                depth = push_string(last_code, 255, 1);
            end else begin
                depth = push_string(code, 256, 0);
            end
            head = byte_stack[depth-1];
            if (free_code < DICT_SIZE) begin
                dict_prefix[free_code[lzwd_pkg::BYTE_W-1:0]] = last_code;
                dict_tail[free_code[lzwd_pkg::BYTE_W-1:0]]   = head;
                ecode     = free_code[lzwd_pkg::CODE_W-1:0];
                evalid    = 1'b1;
                free_code = free_code + lzwd_pkg::NFC_W'(1);
            end
            string_head = head;
            last_code   = code;
        end
        left = depth;
        while (left > 0) begin
            cnt = (left > lzwd_pkg::CHUNK_BYTES) ? lzwd_pkg::CHUNK_BYTES : left;
            r   = '0;
            for (int unsigned k = 0; k < cnt; k++) begin
                r.chunk[lzwd_pkg::BYTE_W*k +: lzwd_pkg::BYTE_W] = byte_stack[left-1-k];
            end
            left          = left - cnt;
            r.byte_count  = cnt[lzwd_pkg::CNT_W-1:0];
            r.last        = (left == 0);
            r.entry_code  = ecode;
            r.entry_valid = evalid;
            queue_chunk(r);
        end
    endtask

    task automatic check_chunk();
        t_chunk e;
        if (pending_chunks.size() == 0) begin
            report_mismatch($sformatf("unexpected chunk %h", i_chunk));
            return;
        end
        e = pending_chunks.pop_front();
        if (i_chunk !== e.chunk)
            report_mismatch($sformatf("chunk %h, want %h", i_chunk, e.chunk));
        if (i_byte_count !== e.byte_count)
            report_mismatch($sformatf("byte_count %0d, want %0d", i_byte_count, e.byte_count));
        if (i_last !== e.last)
            report_mismatch($sformatf("last %b, want %b", i_last, e.last));
        if (i_new_entry_code !== e.entry_code)
            report_mismatch($sformatf("new_entry_code %0d, want %0d",
                                      i_new_entry_code, e.entry_code));
        if (i_new_entry_valid !== e.entry_valid)
            report_mismatch($sformatf("new_entry_valid %b, want %b",
                                      i_new_entry_valid, e.entry_valid));
        if (i_error !== e.error)
            report_mismatch($sformatf("error %b, want %b", i_error, e.error));
    endtask

    // results first: a chunk never comes out in the cycle its code goes in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            last_code   = '0;
            string_head = '0;
            free_code   = lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);
        end else begin
            if (i_out_valid && i_out_ready) check_chunk();
            if (i_in_valid && i_in_ready) decode_code(i_code, i_first_of_message);
        end
        o_outstanding <= pending_chunks.size();
    end

endmodule

// ===== tb/lzw_code_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// lzw_code_decoder_top_tb: drives lzw codes into the decoder with random gaps and
// stalls, and gives the verdict from the checker beside the block
// depends on lzwd_pkg, lzw_code_decoder_top and lzw_code_decoder_checker
module lzw_code_decoder_top_tb;

    localparam int DICT_SIZE   = lzwd_pkg::DICT_SIZE_DEF;
    localparam int CODE_MAX    = (1 << lzwd_pkg::CODE_W) - 1;
    // cycles without any item moving
    localparam int STALL_LIMIT = 20000;

    logic                         i_clk;
    logic                         i_rst_n            = 1'b0;
    logic                         i_valid            = 1'b0;
    logic [lzwd_pkg::CODE_W-1:0]  i_code             = '0;
    logic                         i_first_of_message = 1'b0;
    logic                         i_ready            = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [lzwd_pkg::CHUNK_W-1:0] o_chunk;
    logic [lzwd_pkg::CNT_W-1:0]   o_byte_count;
    logic                         o_last;
    logic [lzwd_pkg::CODE_W-1:0]  o_new_entry_code;
    logic                         o_new_entry_valid;
    logic                         o_error;

    int mismatch_count;
    int chunks_outstanding;

    // idle chances in percent, changed per phase
    int unsigned sender_idle_pct   = 18;
    int unsigned receiver_idle_pct = 47;
    int unsigned items_sent        = 0;
    int unsigned stall_cycles      = 0;

    // what the stimulus knows of the dictionary, only to keep walks on written entries
    logic [lzwd_pkg::CODE_W-1:0] seen_prefix [lzwd_pkg::LIT_LIMIT];
    bit                          seen_written [lzwd_pkg::LIT_LIMIT];
    logic [lzwd_pkg::CODE_W-1:0] seen_last_code = '0;
    logic [lzwd_pkg::NFC_W-1:0]  seen_free_code = lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);

    lzw_code_decoder_top #(
        .DICT_SIZE(DICT_SIZE)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_code            (i_code),
        .i_first_of_message(i_first_of_message),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_chunk           (o_chunk),
        .o_byte_count      (o_byte_count),
        .o_last            (o_last),
        .o_new_entry_code  (o_new_entry_code),
        .o_new_entry_valid (o_new_entry_valid),
        .o_error           (o_error)
    );

    lzw_code_decoder_checker #(
        .DICT_SIZE(DICT_SIZE)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_code            (i_code),
        .i_first_of_message(i_first_of_message),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_chunk           (o_chunk),
        .i_byte_count      (o_byte_count),
        .i_last            (o_last),
        .i_new_entry_code  (o_new_entry_code),
        .i_new_entry_valid (o_new_entry_valid),
        .i_error           (o_error),
        .o_mismatch_count  (mismatch_count),
        .o_outstanding     (chunks_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, a fresh draw every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog: ends the run when no item moves on either channel for too long
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // a non-first code is safe when its walk only touches written entries
    function automatic bit code_is_safe(input logic [lzwd_pkg::CODE_W-1:0] code);
        logic [lzwd_pkg::CODE_W-1:0] c;
        int unsigned                 steps;
        if (code >= seen_free_code) begin
            // kwkwk path walks the previous code
            c     = seen_last_code;
            steps = 255;
        end else begin
            c     = code;
            steps = 256;
        end
        while (c >= lzwd_pkg::LIT_LIMIT && steps > 0) begin
            if (!seen_written[c[lzwd_pkg::BYTE_W-1:0]]) return 1'b0;
            c = seen_prefix[c[lzwd_pkg::BYTE_W-1:0]];
            steps--;
        end
        return 1'b1;
    endfunction

    // called right after a rising edge; returns at the edge that accepts the item
    task automatic send_code(input logic [lzwd_pkg::CODE_W-1:0] code, input logic first);
        // random gap before the item, valid dropped only when a gap is taken
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid            <= 1'b1;
        i_code             <= code;
        i_first_of_message <= first;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        // follow dictionary growth the same way the block does
        if (first) begin
            seen_free_code = lzwd_pkg::NFC_W'(lzwd_pkg::LIT_LIMIT);
            if (code < lzwd_pkg::LIT_LIMIT) seen_last_code = code;
        end else begin
            if (seen_free_code < DICT_SIZE) begin
                seen_written[seen_free_code[lzwd_pkg::BYTE_W-1:0]] = 1'b1;
                seen_prefix[seen_free_code[lzwd_pkg::BYTE_W-1:0]]  = seen_last_code;
                seen_free_code = seen_free_code + lzwd_pkg::NFC_W'(1);
            end
            seen_last_code = code;
        end
    endtask

    // stop sending until every predicted chunk has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chunks_outstanding != 0);
    endtask

    // one message: a literal start, then mostly codes already in the table, with
    // kwkwk codes, codes past the next free one and stray errors mixed in
    task automatic send_random_message(input int unsigned n_codes,
                                       input int unsigned error_pct);
        logic [lzwd_pkg::CODE_W-1:0] code;
        int unsigned                 pick;
        send_code(lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_LIMIT-1)), 1'b1);
        for (int unsigned n = 1; n < n_codes; n++) begin
            pick = $urandom_range(99);
            if (pick < error_pct) begin
                // first flag on a non-literal, then the message carries on
                send_code(lzwd_pkg::CODE_W'($urandom_range(CODE_MAX, lzwd_pkg::LIT_LIMIT)),
                          1'b1);
            end else begin
                if (pick < 12 && seen_free_code <= CODE_MAX)
                    code = seen_free_code[lzwd_pkg::CODE_W-1:0];
                else if (pick < 16 && seen_free_code <= CODE_MAX)
                    code = lzwd_pkg::CODE_W'($urandom_range(CODE_MAX, seen_free_code));
                else if (pick < 40 || seen_free_code == lzwd_pkg::LIT_LIMIT)
                    code = lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_LIMIT-1));
                else
                    code = lzwd_pkg::CODE_W'($urandom_range(seen_free_code - 1,
                                                             lzwd_pkg::LIT_LIMIT));
                if (!code_is_safe(code))
                    code = lzwd_pkg::CODE_W'($urandom_range(lzwd_pkg::LIT_LIMIT-1));
                send_code(code, 1'b0);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, before any message start
        send_code(9'd256, 1'b0);          // kwkwk on previous code zero
        // literal extremes and the classic kwkwk case
        send_code(9'd0, 1'b1);
        send_code(9'd255, 1'b0);
        send_code(9'd256, 1'b0);
        send_code(9'd258, 1'b0);          // code equal to the next free one
        // non-literal first codes
        send_code(9'd511, 1'b1);
        send_code(9'd256, 1'b1);
        send_code(9'd300, 1'b0);          // after an error the old previous code is walked
        // write four entries so the next message can build a loop
        send_code(9'd97, 1'b1);
        send_code(9'd98, 1'b0);
        send_code(9'd99, 1'b0);
        send_code(9'd100, 1'b0);
        send_code(9'd101, 1'b0);
        send_code(9'd65, 1'b1);
        send_code(9'd257, 1'b0);          // code above the next free one
        send_code(9'd256, 1'b0);          // entry 257 now points at itself
        send_code(9'd257, 1'b0);          // overlong chain, 257 bytes in 33 chunks
        send_code(9'd400, 1'b0);          // overlong chain on the kwkwk path

        // random, sender idles less than the receiver
        while (items_sent < 80) send_random_message($urandom_range(30, 1), 3);

        // random, the other way round, with one full pause of the sender
        sender_idle_pct   = 47;
        receiver_idle_pct = 18;
        send_random_message($urandom_range(30, 10), 3);
        drain_results();
        while (items_sent < 150) send_random_message($urandom_range(30, 1), 3);

        // no idling; one longer message without errors
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_message(40, 0);
        while (items_sent < 225) send_random_message($urandom_range(30, 1), 3);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && chunks_outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/lzwd_pkg.sv
design/lzwd_ram.sv
design/lzwd_front.sv
design/lzwd_queue.sv
design/lzwd_back.sv
design/lzw_code_decoder_top.sv
tb/lzw_code_decoder_checker.sv
tb/lzw_code_decoder_top_tb.sv
